// ===== hw/rtl/qrv_pkg.sv =====
package qrv_pkg;

    // Field widths
    localparam int QUAT_W      = 16;
    localparam int COORD_WIDTH = 32;

    // Pairwise quaternion products: exact, 30 fraction bits
    localparam int PROD_W = 32;

    // Matrix entry before rounding, and after doubling and rounding to 15 fraction bits
    localparam int ENTRY_W     = PROD_W + 1;
    localparam int ENTRY_SHIFT = 14;
    localparam int N_W         = ENTRY_W - ENTRY_SHIFT;

    // Entry times coordinate, row sum, and the result before saturation
    localparam int MUL_W     = N_W + COORD_WIDTH;
    localparam int SUM_W     = MUL_W + 2;
    localparam int SUM_SHIFT = 15;
    localparam int RES_W     = SUM_W - SUM_SHIFT + 1;

    // Queue between front and back (depth must be a power of two)
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Register stages in the back end, and the most transactions the block can hold
    localparam int BACK_STAGES   = 4;
    localparam int IN_FLIGHT_MAX = 1 + QUEUE_DEPTH + BACK_STAGES;

    typedef logic signed [QUAT_W-1:0]      t_quat;
    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [PROD_W-1:0]      t_prod;
    typedef logic signed [ENTRY_W-1:0]     t_entry;
    typedef logic signed [N_W-1:0]         t_n;
    typedef logic signed [MUL_W-1:0]       t_mul;
    typedef logic signed [SUM_W-1:0]       t_sum;
    typedef logic signed [RES_W-1:0]       t_res;

    localparam t_entry ROUND_E = ENTRY_W'(1) << (ENTRY_SHIFT - 1);
    localparam t_sum   ROUND_S = SUM_W'(1) << (SUM_SHIFT - 1);

    // One queued transaction: the nine products and the vector
    typedef struct packed {
        t_prod  ab;
        t_prod  ac;
        t_prod  ad;
        t_prod  bb;
        t_prod  bc;
        t_prod  bd;
        t_prod  cc;
        t_prod  cd;
        t_prod  dd;
        t_coord vx;
        t_coord vy;
        t_coord vz;
    } t_qentry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ===== hw/rtl/qrv_in_if.sv =====
interface qrv_in_if;
    import qrv_pkg::*;

    logic   valid;
    logic   ready;
    t_quat  quat_x;
    t_quat  quat_y;
    t_quat  quat_z;
    t_quat  quat_w;
    t_coord vec_x;
    t_coord vec_y;
    t_coord vec_z;

    modport source (
        output valid, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z,
        input  ready
    );
    modport sink (
        input  valid, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z,
        output ready
    );
endinterface

// ===== hw/rtl/qrv_out_if.sv =====
interface qrv_out_if;
    import qrv_pkg::*;

    logic   valid;
    logic   ready;
    t_coord rot_x;
    t_coord rot_y;
    t_coord rot_z;

    modport source (
        output valid, rot_x, rot_y, rot_z,
        input  ready
    );
    modport sink (
        input  valid, rot_x, rot_y, rot_z,
        output ready
    );
endinterface

// ===== hw/rtl/qrv_front.sv =====
module qrv_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    qrv_in_if.sink           i_vec,
    input  qrv_pkg::t_qstat  i_qstat,
    output logic             o_push,
    output qrv_pkg::t_qentry o_entry
);
    import qrv_pkg::*;

    function automatic t_prod f_mul(input logic signed [QUAT_W:0] p,
                                    input logic signed [QUAT_W:0] q);
        logic signed [2*QUAT_W+1:0] full;
        full = p * q;
        return full[PROD_W-1:0];
    endfunction

    logic                    r_fv;
    t_qentry                 r_entry;
    logic signed [QUAT_W:0]  w_a;
    logic signed [QUAT_W:0]  w_b;
    logic signed [QUAT_W:0]  w_c;
    logic signed [QUAT_W:0]  w_d;
    logic                    w_accept;

    // Negate the scalar part; the most negative code becomes exactly +1.0
    assign w_a = -$signed({i_vec.quat_w[QUAT_W-1], i_vec.quat_w});
    assign w_b = $signed({i_vec.quat_x[QUAT_W-1], i_vec.quat_x});
    assign w_c = $signed({i_vec.quat_y[QUAT_W-1], i_vec.quat_y});
    assign w_d = $signed({i_vec.quat_z[QUAT_W-1], i_vec.quat_z});

    assign o_push      = r_fv && !i_qstat.full;
    assign i_vec.ready = !r_fv || !i_qstat.full;
    assign w_accept    = i_vec.valid && i_vec.ready;
    assign o_entry     = r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (w_accept) begin
            r_fv <= 1'b1;
        end else if (o_push) begin
            r_fv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_entry.ab <= f_mul(w_a, w_b);
            r_entry.ac <= f_mul(w_a, w_c);
            r_entry.ad <= f_mul(w_a, w_d);
            r_entry.bb <= f_mul(w_b, w_b);
            r_entry.bc <= f_mul(w_b, w_c);
            r_entry.bd <= f_mul(w_b, w_d);
            r_entry.cc <= f_mul(w_c, w_c);
            r_entry.cd <= f_mul(w_c, w_d);
            r_entry.dd <= f_mul(w_d, w_d);
            r_entry.vx <= i_vec.vec_x;
            r_entry.vy <= i_vec.vec_y;
            r_entry.vz <= i_vec.vec_z;
        end
    end
endmodule

// ===== hw/rtl/qrv_queue.sv =====
module qrv_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  qrv_pkg::t_qentry i_entry,
    input  logic             i_pop,
    output qrv_pkg::t_qentry o_head,
    output qrv_pkg::t_qstat  o_qstat
);
    import qrv_pkg::*;

    t_qentry               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wp;
    logic [QUEUE_AW-1:0]   r_rp;
    logic [QUEUE_AW:0]     r_cnt;

    assign o_head        = r_mem[r_rp];
    assign o_qstat.full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_qstat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end
endmodule

// ===== hw/rtl/qrv_back.sv =====
module qrv_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  qrv_pkg::t_qentry i_head,
    input  qrv_pkg::t_qstat  i_qstat,
    output logic             o_pop,
    qrv_out_if.source        o_rot
);
    import qrv_pkg::*;

    function automatic t_entry f_ext(input t_prod p);
        return {{(ENTRY_W-PROD_W){p[PROD_W-1]}}, p};
    endfunction

    // Double and round half up to 15 fraction bits
    function automatic t_n f_round(input t_entry m);
        t_entry t;
        t = m + ROUND_E;
        return t[ENTRY_W-1:ENTRY_SHIFT];
    endfunction

    function automatic t_mul f_mul(input t_n n, input t_coord v);
        t_mul p;
        p = n * v;
        return p;
    endfunction

    function automatic t_sum f_sx(input t_mul p);
        return {{(SUM_W-MUL_W){p[MUL_W-1]}}, p};
    endfunction

    // Add the rounded row sum to the coordinate and clamp
    function automatic t_coord f_sat(input t_coord v, input t_sum s);
        t_res t;
        logic [RES_W-COORD_WIDTH:0] upper;
        t = $signed({{(RES_W-COORD_WIDTH){v[COORD_WIDTH-1]}}, v})
            + $signed({s[SUM_W-1], s[SUM_W-1:SUM_SHIFT]});
        upper = t[RES_W-1:COORD_WIDTH-1];
        if ((&upper) || !(|upper)) begin
            return t[COORD_WIDTH-1:0];
        end
        return t[RES_W-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                          : {1'b0, {(COORD_WIDTH-1){1'b1}}};
    endfunction

    logic   w_en;
    t_n     w_n    [3][3];
    t_coord w_vec  [3];
    logic   r_v0, r_v1, r_v2, r_ov;
    t_n     r_n    [3][3];
    t_coord r_vec0 [3];
    t_mul   r_pr   [3][3];
    t_coord r_vec1 [3];
    t_sum   r_s    [3];
    t_coord r_vec2 [3];
    t_coord r_rot  [3];

    assign w_en  = !r_ov || o_rot.ready;
    assign o_pop = w_en && !i_qstat.empty;

    always_comb begin
        w_n[0][0] = f_round(-(f_ext(i_head.cc) + f_ext(i_head.dd)));
        w_n[0][1] = f_round(f_ext(i_head.bc) - f_ext(i_head.ad));
        w_n[0][2] = f_round(f_ext(i_head.ac) + f_ext(i_head.bd));
        w_n[1][0] = f_round(f_ext(i_head.ad) + f_ext(i_head.bc));
        w_n[1][1] = f_round(-(f_ext(i_head.bb) + f_ext(i_head.dd)));
        w_n[1][2] = f_round(f_ext(i_head.cd) - f_ext(i_head.ab));
        w_n[2][0] = f_round(f_ext(i_head.bd) - f_ext(i_head.ac));
        w_n[2][1] = f_round(f_ext(i_head.ab) + f_ext(i_head.cd));
        w_n[2][2] = f_round(-(f_ext(i_head.bb) + f_ext(i_head.cc)));
        w_vec[0]  = i_head.vx;
        w_vec[1]  = i_head.vy;
        w_vec[2]  = i_head.vz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_v0 <= !i_qstat.empty;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_ov <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_n    <= w_n;
            r_vec0 <= w_vec;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_pr[i][j] <= f_mul(r_n[i][j], r_vec0[j]);
                end
            end
            r_vec1 <= r_vec0;
            for (int i = 0; i < 3; i++) begin
                r_s[i] <= f_sx(r_pr[i][0]) + f_sx(r_pr[i][1]) + f_sx(r_pr[i][2]) + ROUND_S;
            end
            r_vec2 <= r_vec1;
            for (int i = 0; i < 3; i++) begin
                r_rot[i] <= f_sat(r_vec2[i], r_s[i]);
            end
        end
    end

    assign o_rot.valid = r_ov;
    assign o_rot.rot_x = r_rot[0];
    assign o_rot.rot_y = r_rot[1];
    assign o_rot.rot_z = r_rot[2];
endmodule

// ===== hw/rtl/quaternion_rotate_vector_top.sv =====
// Path from i_vec to o_rot: front register, queue, then the four back stages.
// Throughput: one transaction per cycle while the queue has room; the back pipeline
// stalls only while a result waits on o_rot.ready; the four-entry queue absorbs it.
// Up to 9 transactions in flight (front register, queue, four back stages).
// Reset: synchronous, active low; clears valid bits, queue pointers and count only.
module quaternion_rotate_vector_top (
    input  logic     i_clk,
    input  logic     i_rst_n,
    qrv_in_if.sink   i_vec,
    qrv_out_if.source o_rot
);
    import qrv_pkg::*;

    // Front -> queue
    logic    w_push;
    t_qentry w_entry;

    // Queue -> back
    logic    w_pop;
    t_qentry w_head;
    t_qstat  w_qstat;

    // Front: accept the transaction, negate the scalar part and register the
    // nine pairwise products next to the vector. Ready depends only on the
    // front register and the queue fill, never on o_rot.ready.
    qrv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vec   (i_vec),
        .i_qstat (w_qstat),
        .o_push  (w_push),
        .o_entry (w_entry)
    );

    // Queue: decouple the front from output backpressure.
    qrv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_qstat (w_qstat)
    );

    // Back: form and round the matrix entries, multiply by the vector,
    // sum each row with rounding, add the coordinate and saturate.
    // Advance all stages together whenever the output register is free
    // or being drained.
    qrv_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_qstat (w_qstat),
        .o_pop   (w_pop),
        .o_rot   (o_rot)
    );
endmodule

// ===== hw/rtl/qrv_checker.sv =====
module qrv_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            i_in_ready,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input qrv_pkg::t_coord i_rot_x,
    input qrv_pkg::t_coord i_rot_y,
    input qrv_pkg::t_coord i_rot_z
);
    import qrv_pkg::*;

    localparam int CNT_W = $clog2(IN_FLIGHT_MAX + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             w_in_acc;
    logic             w_out_acc;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;

    // Track transactions accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_in_acc && !w_out_acc) begin
            r_cnt <= r_cnt + 1'b1;
        end else if (w_out_acc && !w_in_acc) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_rot_x)
            && $stable(i_rot_y) && $stable(i_rot_z))
        else $error("result dropped or changed while stalled");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_cnt != '0)
        else $error("result without an accepted transaction");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(IN_FLIGHT_MAX))
        else $error("more transactions in flight than the block can hold");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == '0 |-> i_in_ready && !i_out_valid)
        else $error("empty block not ready or showing a result");
endmodule

bind quaternion_rotate_vector_top qrv_checker u_qrv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_vec.valid),
    .i_in_ready  (i_vec.ready),
    .i_out_valid (o_rot.valid),
    .i_out_ready (o_rot.ready),
    .i_rot_x     (o_rot.rot_x),
    .i_rot_y     (o_rot.rot_y),
    .i_rot_z     (o_rot.rot_z)
);
